// File: hw/rtl/quaternion_to_euler_angles_defines.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define QTE_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("quaternion_to_euler_angles: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define QTE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("quaternion_to_euler_angles: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define QTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("quaternion_to_euler_angles: next-cycle check violated");

`endif

// File: hw/rtl/qte_pkg.sv
package qte_pkg;

  localparam int unsigned CORDIC_STEPS   = 16;
  localparam int unsigned COMPONENT_BITS = 16;

  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned ANGLE_W   = 16;
  // product of two components at 30 fraction bits, magnitude <= 1.0
  localparam int unsigned P_W  = 33;
  // sums: sr, cr, sy, cy, 1 +/- 2t
  localparam int unsigned S_W  = 34;
  // clamped radicand, below 5.0
  localparam int unsigned R_W  = 33;
  // square root result bits
  localparam int unsigned SQ_W = 32;
  // square root working registers
  localparam int unsigned N_W  = 64;
  // CORDIC x/y datapath (input magnitude times gain stays below 2^35)
  localparam int unsigned CW   = 38;
  // CORDIC angle accumulator, 2^32 units per turn
  localparam int unsigned ZW   = 34;

  localparam logic signed [S_W-1:0] ONE_FIX      = S_W'(1) <<< FRAC_BITS;
  localparam logic signed [ZW-1:0]  QUARTER_TURN = ZW'(1) <<< 30;

  localparam logic [31:0] ATAN_UNITS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctl_t;

endpackage

// File: hw/rtl/qte_if.sv
interface qte_quat_if #(
  parameter int unsigned W = qte_pkg::COMPONENT_BITS
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_w;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink (input valid, input quat_w, input quat_x, input quat_y,
                input quat_z, output ready);
endinterface

interface qte_euler_if;
  logic                                valid;
  logic                                ready;
  logic signed [qte_pkg::ANGLE_W-1:0] roll_angle;
  logic signed [qte_pkg::ANGLE_W-1:0] pitch_angle;
  logic signed [qte_pkg::ANGLE_W-1:0] yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, input ready);
  modport sink (input valid, input roll_angle, input pitch_angle,
                input yaw_angle, output ready);
endinterface

// File: hw/rtl/qte_front.sv
module qte_front #(
  parameter int unsigned COMPONENT_BITS = qte_pkg::COMPONENT_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  qte_pkg::pipe_ctl_t                 ctl_i,
  input  logic signed [COMPONENT_BITS-1:0]   w_i,
  input  logic signed [COMPONENT_BITS-1:0]   x_i,
  input  logic signed [COMPONENT_BITS-1:0]   y_i,
  input  logic signed [COMPONENT_BITS-1:0]   z_i,
  output logic                               valid_o,
  output logic signed [qte_pkg::S_W-1:0]     sr_o,
  output logic signed [qte_pkg::S_W-1:0]     cr_o,
  output logic signed [qte_pkg::S_W-1:0]     sy_o,
  output logic signed [qte_pkg::S_W-1:0]     cy_o,
  output logic        [qte_pkg::R_W-1:0]     ra_o,
  output logic        [qte_pkg::R_W-1:0]     rb_o
);

  localparam int unsigned CB  = COMPONENT_BITS;
  localparam int unsigned FB  = 2 * (CB - 1);
  localparam int unsigned SHR = (FB >= qte_pkg::FRAC_BITS) ? FB - qte_pkg::FRAC_BITS : 0;
  localparam int unsigned SHL = (FB >= qte_pkg::FRAC_BITS) ? 0 : qte_pkg::FRAC_BITS - FB;
  localparam int unsigned P_W = qte_pkg::P_W;
  localparam int unsigned S_W = qte_pkg::S_W;
  localparam int unsigned R_W = qte_pkg::R_W;

  // Product scaled to 30 fraction bits, floor on the way down.
  function automatic logic signed [P_W-1:0] mul_fix(input logic signed [CB-1:0] a,
                                                    input logic signed [CB-1:0] b);
    logic signed [2*CB-1:0] p;
    logic signed [63:0]     e;
    p = a * b;
    e = 64'(p);
    e = (e >>> SHR) <<< SHL;
    return e[P_W-1:0];
  endfunction

  function automatic logic signed [S_W-1:0] ext(input logic signed [P_W-1:0] p);
    return S_W'(p);
  endfunction

  logic                  v1_q, v2_q;
  logic signed [P_W-1:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, xz_q;
  logic signed [S_W-1:0] sr_d, cr_d, sy_d, cy_d, t_d, ra_d, rb_d;
  logic signed [S_W-1:0] sr_q, cr_q, sy_q, cy_q;
  logic        [R_W-1:0] ra_q, rb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (ctl_i.advance) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    sr_d = (ext(wx_q) + ext(yz_q)) <<< 1;
    cr_d = qte_pkg::ONE_FIX - ((ext(xx_q) + ext(yy_q)) <<< 1);
    sy_d = (ext(wz_q) + ext(xy_q)) <<< 1;
    cy_d = qte_pkg::ONE_FIX - ((ext(yy_q) + ext(zz_q)) <<< 1);
    t_d  = ext(wy_q) - ext(xz_q);
    ra_d = qte_pkg::ONE_FIX + (t_d <<< 1);
    rb_d = qte_pkg::ONE_FIX - (t_d <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      wx_q <= mul_fix(w_i, x_i);
      yz_q <= mul_fix(y_i, z_i);
      xx_q <= mul_fix(x_i, x_i);
      yy_q <= mul_fix(y_i, y_i);
      wz_q <= mul_fix(w_i, z_i);
      xy_q <= mul_fix(x_i, y_i);
      zz_q <= mul_fix(z_i, z_i);
      wy_q <= mul_fix(w_i, y_i);
      xz_q <= mul_fix(x_i, z_i);
      sr_q <= sr_d;
      cr_q <= cr_d;
      sy_q <= sy_d;
      cy_q <= cy_d;
      // clamp a negative radicand to zero
      ra_q <= ra_d[S_W-1] ? '0 : ra_d[R_W-1:0];
      rb_q <= rb_d[S_W-1] ? '0 : rb_d[R_W-1:0];
    end
  end

  assign valid_o = v2_q;
  assign sr_o    = sr_q;
  assign cr_o    = cr_q;
  assign sy_o    = sy_q;
  assign cy_o    = cy_q;
  assign ra_o    = ra_q;
  assign rb_o    = rb_q;

endmodule

// File: hw/rtl/qte_sqrt.sv
module qte_sqrt #(
  parameter int unsigned SIDE_W = 4 * qte_pkg::S_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  qte_pkg::pipe_ctl_t         ctl_i,
  input  logic [qte_pkg::R_W-1:0]    ra_i,
  input  logic [qte_pkg::R_W-1:0]    rb_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [qte_pkg::SQ_W-1:0]   ra_root_o,
  output logic [qte_pkg::SQ_W-1:0]   rb_root_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int unsigned NS  = qte_pkg::SQ_W;
  localparam int unsigned N_W = qte_pkg::N_W;

  // Two lanes, one result bit per stage.
  logic [N_W-1:0]    n_q   [NS][2];
  logic [N_W-1:0]    res_q [NS][2];
  logic [N_W-1:0]    n_d   [NS][2];
  logic [N_W-1:0]    res_d [NS][2];
  logic [NS-1:0]     v_q;
  logic [SIDE_W-1:0] side_q [NS];

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < 2; l++) begin
        logic [N_W-1:0] n_in, res_in, bit_v, trial;
        if (s == 0) begin
          n_in   = N_W'(l == 0 ? ra_i : rb_i) << qte_pkg::FRAC_BITS;
          res_in = '0;
        end else begin
          n_in   = n_q[s-1][l];
          res_in = res_q[s-1][l];
        end
        bit_v = N_W'(1) << (2 * (NS - 1 - s));
        trial = res_in + bit_v;
        if (n_in >= trial) begin
          n_d[s][l]   = n_in - trial;
          res_d[s][l] = (res_in >> 1) + bit_v;
        end else begin
          n_d[s][l]   = n_in;
          res_d[s][l] = res_in >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.advance) begin
      v_q <= {v_q[NS-2:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      for (int s = 0; s < NS; s++) begin
        n_q[s]   <= n_d[s];
        res_q[s] <= res_d[s];
        side_q[s] <= (s == 0) ? side_i : side_q[s-1];
      end
    end
  end

  assign valid_o   = v_q[NS-1];
  assign ra_root_o = res_q[NS-1][0][NS-1:0];
  assign rb_root_o = res_q[NS-1][1][NS-1:0];
  assign side_o    = side_q[NS-1];

endmodule

// File: hw/rtl/qte_cordic.sv
module qte_cordic #(
  parameter int unsigned CORDIC_STEPS = qte_pkg::CORDIC_STEPS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  qte_pkg::pipe_ctl_t              ctl_i,
  input  logic signed [qte_pkg::S_W-1:0]  y_i,
  input  logic signed [qte_pkg::S_W-1:0]  x_i,
  output logic                            valid_o,
  output logic signed [qte_pkg::ZW-1:0]   z_o
);

  localparam int unsigned NS = CORDIC_STEPS;
  localparam int unsigned CW = qte_pkg::CW;
  localparam int unsigned ZW = qte_pkg::ZW;

  // Index 0 is the pre-rotation stage, index i+1 the result of step i.
  logic signed [CW-1:0] x_q [NS+1];
  logic signed [CW-1:0] y_q [NS+1];
  logic signed [ZW-1:0] z_q [NS+1];
  logic [NS:0]          zero_q;
  logic [NS:0]          v_q;
  logic signed [CW-1:0] x_d [NS];
  logic signed [CW-1:0] y_d [NS];
  logic signed [ZW-1:0] z_d [NS];
  logic signed [CW-1:0] x0_d, y0_d, xe, ye;
  logic signed [ZW-1:0] z0_d;

  // Pre-rotate a left half-plane vector by a quarter turn.
  always_comb begin
    xe = CW'(x_i);
    ye = CW'(y_i);
    x0_d = xe;
    y0_d = ye;
    z0_d = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0_d = ye;
        y0_d = -xe;
        z0_d = qte_pkg::QUARTER_TURN;
      end else begin
        x0_d = -ye;
        y0_d = xe;
        z0_d = -qte_pkg::QUARTER_TURN;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      logic signed [CW-1:0] dx, dy;
      logic signed [ZW-1:0] da;
      dx = y_q[i] >>> i;
      dy = x_q[i] >>> i;
      da = signed'(ZW'(qte_pkg::ATAN_UNITS[i]));
      if (y_q[i] > 0) begin
        x_d[i] = x_q[i] + dx;
        y_d[i] = y_q[i] - dy;
        z_d[i] = z_q[i] + da;
      end else begin
        x_d[i] = x_q[i] - dx;
        y_d[i] = y_q[i] + dy;
        z_d[i] = z_q[i] - da;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.advance) begin
      v_q <= {v_q[NS-1:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      x_q[0]    <= x0_d;
      y_q[0]    <= y0_d;
      z_q[0]    <= z0_d;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      for (int i = 0; i < NS; i++) begin
        x_q[i+1]    <= x_d[i];
        y_q[i+1]    <= y_d[i];
        z_q[i+1]    <= z_d[i];
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  assign valid_o = v_q[NS];
  assign z_o     = zero_q[NS] ? '0 : z_q[NS];

endmodule

// File: hw/rtl/quaternion_to_euler_angles.sv
// Quaternion to roll/pitch/yaw binary angles, fully pipelined.
// Stages: 2 product/sum stages, 32 square-root stages, 1 pre-rotation and
// CORDIC_STEPS CORDIC stages, 1 round stage.
// Throughput: one transfer per cycle in and out while the skid is empty; a result the
// sink does not take waits in the output skid register and the whole pipeline freezes.
// Reset: asynchronous active low, clears all valid bits and the skid; no data is reset.
module quaternion_to_euler_angles #(
  parameter int unsigned CORDIC_STEPS   = qte_pkg::CORDIC_STEPS
) (
  input logic       clk_i,
  input logic       rst_ni,
  qte_quat_if.sink  quat_i,
  qte_euler_if.source euler_o
);

`include "quaternion_to_euler_angles_defines.svh"

  localparam int unsigned S_W  = qte_pkg::S_W;
  localparam int unsigned R_W  = qte_pkg::R_W;
  localparam int unsigned SQ_W = qte_pkg::SQ_W;
  localparam int unsigned ZW   = qte_pkg::ZW;
  localparam int unsigned AW   = qte_pkg::ANGLE_W;
  localparam int unsigned SIDE_W = 4 * S_W;
  localparam int unsigned PW   = ZW + 2;

  // The whole pipeline moves together; it freezes only while the skid holds a result.
  logic               skid_q;
  logic               advance;
  qte_pkg::pipe_ctl_t ctl_in, ctl_front, ctl_sqrt;

  assign advance      = !skid_q;
  assign quat_i.ready = advance;

  assign ctl_in = '{advance: advance, valid: quat_i.valid};

  // Products and sums.
  logic                  front_v;
  logic signed [S_W-1:0] sr, cr, sy, cy;
  logic        [R_W-1:0] ra, rb;

  qte_front #(.COMPONENT_BITS(qte_pkg::COMPONENT_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_in),
    .w_i     (quat_i.quat_w),
    .x_i     (quat_i.quat_x),
    .y_i     (quat_i.quat_y),
    .z_i     (quat_i.quat_z),
    .valid_o (front_v),
    .sr_o    (sr),
    .cr_o    (cr),
    .sy_o    (sy),
    .cy_o    (cy),
    .ra_o    (ra),
    .rb_o    (rb)
  );

  // Square roots for pitch; roll and yaw operands ride alongside.
  logic              sqrt_v;
  logic [SQ_W-1:0]   ra_root, rb_root;
  logic [SIDE_W-1:0] side;
  logic signed [S_W-1:0] sr_s, cr_s, sy_s, cy_s;

  assign ctl_front = '{advance: advance, valid: front_v};

  qte_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_front),
    .ra_i      (ra),
    .rb_i      (rb),
    .side_i    ({sr, cr, sy, cy}),
    .valid_o   (sqrt_v),
    .ra_root_o (ra_root),
    .rb_root_o (rb_root),
    .side_o    (side)
  );

  assign {sr_s, cr_s, sy_s, cy_s} = side;
  assign ctl_sqrt = '{advance: advance, valid: sqrt_v};

  // Three atan2 lanes in lockstep.
  logic                 v_roll, v_pitch, v_yaw;
  logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;

  qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_sqrt),
    .y_i     (sr_s),
    .x_i     (cr_s),
    .valid_o (v_roll),
    .z_o     (z_roll)
  );

  qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_sqrt),
    .y_i     (signed'(S_W'(ra_root))),
    .x_i     (signed'(S_W'(rb_root))),
    .valid_o (v_pitch),
    .z_o     (z_pitch)
  );

  qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_sqrt),
    .y_i     (sy_s),
    .x_i     (cy_s),
    .valid_o (v_yaw),
    .z_o     (z_yaw)
  );

  // Round half up to 16 bits; pitch is doubled, shifted by a quarter turn and saturated.
  localparam logic signed [PW-1:0] PITCH_MAX = PW'(16384);
  localparam logic signed [PW-1:0] PITCH_MIN = -PW'(16384);
  localparam logic signed [ZW-1:0] HALF_LSB  = ZW'(1) <<< 15;

  logic signed [ZW-1:0] roll_r, yaw_r;
  logic signed [PW-1:0] pitch_sum, pitch_r;
  logic signed [AW-1:0] roll_d, pitch_d, yaw_d;

  always_comb begin
    roll_r    = (z_roll + HALF_LSB) >>> 16;
    yaw_r     = (z_yaw + HALF_LSB) >>> 16;
    pitch_sum = (PW'(z_pitch) <<< 1) - PW'(qte_pkg::QUARTER_TURN) + PW'(HALF_LSB);
    pitch_r   = pitch_sum >>> 16;
    // plus pi wraps to minus pi by truncation
    roll_d    = roll_r[AW-1:0];
    yaw_d     = yaw_r[AW-1:0];
    if (pitch_r > PITCH_MAX) begin
      pitch_d = PITCH_MAX[AW-1:0];
    end else if (pitch_r < PITCH_MIN) begin
      pitch_d = PITCH_MIN[AW-1:0];
    end else begin
      pitch_d = pitch_r[AW-1:0];
    end
  end

  logic                 out_v_q;
  logic signed [AW-1:0] roll_q, pitch_q, yaw_q;
  logic signed [AW-1:0] skid_roll_q, skid_pitch_q, skid_yaw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_q  <= 1'b0;
    end else begin
      if (advance) begin
        out_v_q <= v_pitch;
        // park the presented result if the sink does not take it
        skid_q  <= out_v_q && !euler_o.ready;
      end else if (euler_o.ready) begin
        skid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      roll_q       <= roll_d;
      pitch_q      <= pitch_d;
      yaw_q        <= yaw_d;
      skid_roll_q  <= roll_q;
      skid_pitch_q <= pitch_q;
      skid_yaw_q   <= yaw_q;
    end
  end

  assign euler_o.valid       = skid_q || out_v_q;
  assign euler_o.roll_angle  = skid_q ? skid_roll_q  : roll_q;
  assign euler_o.pitch_angle = skid_q ? skid_pitch_q : pitch_q;
  assign euler_o.yaw_angle   = skid_q ? skid_yaw_q   : yaw_q;

  `QTE_ASSERT_ALWAYS(a_lanes_aligned, (v_roll == v_pitch) && (v_pitch == v_yaw))
  `QTE_ASSERT_IMPL(a_skid_presented, skid_q, euler_o.valid)
  `QTE_ASSERT_NEXT(a_skid_holds, skid_q && !euler_o.ready, skid_q && $stable(skid_pitch_q))
  `QTE_ASSERT_IMPL(a_pitch_range, euler_o.valid, (euler_o.pitch_angle >= -16'sd16384) && (euler_o.pitch_angle <= 16'sd16384))

endmodule

// File: tb/tb_quaternion_to_euler_angles.sv
module tb_quaternion_to_euler_angles;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  // Stall patterns, one per phase.
  typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_e;

  localparam int LATENCY   = qte_pkg::CORDIC_STEPS + 36;
  localparam int WDOG_MAX  = 20000;
  localparam int HOLD_LEN  = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qte_quat_if  quat_if ();
  qte_euler_if euler_if ();

  quaternion_to_euler_angles dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .quat_i (quat_if.sink),
    .euler_o(euler_if.source)
  );

  always #5 clk_i = ~clk_i;

  quat_t  pending_quats[$];
  euler_t expected_angles[$];
  phase_e phase = PH_FREE;
  int     error_count = 0;
  int     hold_cycles = 0;   // sink holds off while this is non-zero
  bit     pause_src = 1'b0;  // sender pauses until the pipe drains
  bit     in_fire = 1'b0;    // input transfer seen at the last rising edge

  // ---------------------------------------------------------------------
  // Predictor: fixed-point angle math in 64-bit signed terms.
  // ---------------------------------------------------------------------
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;  // arithmetic shift floors toward minus infinity
  endfunction

  function automatic longint prod_q30(longint a, longint b);
    // Q1.15 * Q1.15 gives 30 fraction bits directly.
    return a * b;
  endfunction

  function automatic longint atan_units_tbl(int i);
    longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                        21354465, 10679838, 5340245, 2670163, 1335087,
                        667544, 333772, 166886, 83443, 41722, 20861,
                        10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  // Vectoring CORDIC, angle in 2^32 units per turn.
  function automatic longint vec_angle(longint y, longint x);
    longint ang, tmp, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    // Rotate a left-half vector into the right half first.
    if (x < 0) begin
      tmp = x;
      if (y >= 0) begin
        x = y; y = -tmp; ang = 64'sd1 <<< 30;
      end else begin
        x = -y; y = tmp; ang = -(64'sd1 <<< 30);
      end
    end
    for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 24; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += atan_units_tbl(i);
      end else begin
        x -= dx; y += dy; ang -= atan_units_tbl(i);
      end
    end
    return ang;
  endfunction

  function automatic longint round_angle(longint a);
    return floor_shift(a + (64'sd1 <<< 15), 16);
  endfunction

  // Truncated square root, 30 fraction bits in and out.
  function automatic longint root_q30(longint a);
    logic [63:0] n, res, b;
    if (a <= 0) return 0;
    n = 64'(a) << 30;
    res = 0;
    for (int k = 31; k >= 0; k--) begin
      b = 64'd1 << (2 * k);
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
    end
    return longint'(res);
  endfunction

  function automatic euler_t quat_to_euler(quat_t q);
    longint w, x, y, z, sr, cr, sy, cy, t, ra, rb, p, one;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    one = 64'sd1 <<< 30;
    sr = 2 * (prod_q30(w, x) + prod_q30(y, z));
    cr = one - 2 * (prod_q30(x, x) + prod_q30(y, y));
    sy = 2 * (prod_q30(w, z) + prod_q30(x, y));
    cy = one - 2 * (prod_q30(y, y) + prod_q30(z, z));
    t  = prod_q30(w, y) - prod_q30(x, z);
    // Clamp negative radicands to zero.
    ra = one + 2 * t; if (ra < 0) ra = 0;
    rb = one - 2 * t; if (rb < 0) rb = 0;
    p = round_angle(2 * vec_angle(root_q30(ra), root_q30(rb)) - one);
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    e.roll  = 16'(round_angle(vec_angle(sr, cr)));
    e.pitch = 16'(p);
    e.yaw   = 16'(round_angle(vec_angle(sy, cy)));
    return e;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offer items at the falling edge; advance on a transfer.
  // ---------------------------------------------------------------------
  function automatic bit src_idle_now();
    case (phase)
      PH_SRC_IDLE, PH_BOTH: return $urandom_range(99) < ((phase == PH_BOTH) ? 16 : 49);
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit snk_stall_now();
    if (hold_cycles > 0) return 1'b1;
    case (phase)
      PH_SNK_STALL, PH_BOTH: return $urandom_range(99) < ((phase == PH_BOTH) ? 16 : 49);
      default: return 1'b0;
    endcase
  endfunction

  initial begin
    quat_if.valid  = 1'b0;
    quat_if.quat_w = '0;
    quat_if.quat_x = '0;
    quat_if.quat_y = '0;
    quat_if.quat_z = '0;
    euler_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    // Drop the current item once it was transferred at the last rising edge.
    if (in_fire) begin
      expected_angles.push_back(quat_to_euler(pending_quats.pop_front()));
    end
    if (rst_ni && pending_quats.size() > 0 && !pause_src && !src_idle_now()) begin
      quat_if.valid  <= 1'b1;
      quat_if.quat_w <= pending_quats[0].w;
      quat_if.quat_x <= pending_quats[0].x;
      quat_if.quat_y <= pending_quats[0].y;
      quat_if.quat_z <= pending_quats[0].z;
    end else begin
      quat_if.valid <= 1'b0;
    end
    euler_if.ready <= rst_ni && !snk_stall_now();
  end

  // Count down the long sink hold-off.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest expectation.
  // ---------------------------------------------------------------------
  int idle_count = 0;

  always @(posedge clk_i) begin
    euler_t exp_e;
    in_fire = quat_if.valid && quat_if.ready;
    if (rst_ni) begin
      if (euler_if.valid && euler_if.ready) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: result with nothing expected: roll %0d pitch %0d yaw %0d",
                   $time, euler_if.roll_angle, euler_if.pitch_angle,
                   euler_if.yaw_angle);
          error_count++;
        end else begin
          exp_e = expected_angles.pop_front();
          if (euler_if.roll_angle !== exp_e.roll) begin
            $display("%0t: roll mismatch: expected %0d actual %0d",
                     $time, exp_e.roll, euler_if.roll_angle);
            error_count++;
          end
          if (euler_if.pitch_angle !== exp_e.pitch) begin
            $display("%0t: pitch mismatch: expected %0d actual %0d",
                     $time, exp_e.pitch, euler_if.pitch_angle);
            error_count++;
          end
          if (euler_if.yaw_angle !== exp_e.yaw) begin
            $display("%0t: yaw mismatch: expected %0d actual %0d",
                     $time, exp_e.yaw, euler_if.yaw_angle);
            error_count++;
          end
        end
      end
      // Watchdog: count cycles with no transfer on either side.
      if ((quat_if.valid && quat_if.ready) || (euler_if.valid && euler_if.ready))
        idle_count <= 0;
      else
        idle_count <= idle_count + 1;
      if (idle_count > WDOG_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    return q;
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Near-unit quaternion with random direction, roughly normalized.
  function automatic quat_t unit_quat();
    real a, b, c, d, n;
    quat_t q;
    a = real'(int'($urandom_range(20000)) - 10000);
    b = real'(int'($urandom_range(20000)) - 10000);
    c = real'(int'($urandom_range(20000)) - 10000);
    d = real'(int'($urandom_range(20000)) - 10000);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) n = 1.0;
    q.w = 16'($rtoi(a / n * 32767.0));
    q.x = 16'($rtoi(b / n * 32767.0));
    q.y = 16'($rtoi(c / n * 32767.0));
    q.z = 16'($rtoi(d / n * 32767.0));
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_quats.size() > 0 || quat_if.valid || expected_angles.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    quat_t q;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: identity, axes, extremes, gimbal lock on both sides,
    // negative radicands, zero operands and non-unit inputs.
    pending_quats.push_back(make_quat(32767, 0, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 0, 0));
    pending_quats.push_back(make_quat(-32768, 0, 0, 0));
    pending_quats.push_back(make_quat(0, 32767, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 32767, 0));
    pending_quats.push_back(make_quat(0, 0, 0, 32767));
    pending_quats.push_back(make_quat(0, -32768, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 0, -32768));
    pending_quats.push_back(make_quat(23170, 0, 23170, 0));
    pending_quats.push_back(make_quat(23170, 0, -23170, 0));
    pending_quats.push_back(make_quat(32767, 0, 32767, 0));
    pending_quats.push_back(make_quat(-32768, 0, 32767, 0));
    pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
    pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
    pending_quats.push_back(make_quat(32767, -32768, 32767, -32768));
    pending_quats.push_back(make_quat(0, 23170, 0, 23170));
    pending_quats.push_back(make_quat(0, 23170, 0, -23170));
    pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
    pending_quats.push_back(make_quat(16384, -16384, 16384, 16384));
    pending_quats.push_back(make_quat(1, -1, 1, -1));
    pending_quats.push_back(make_quat(0, 0, -23170, 23170));
    wait_drained();

    // Random phases: mostly near-unit rotations, some raw noise.
    for (int ph = 0; ph < 4; ph++) begin
      phase = phase_e'(ph);
      for (int i = 0; i < 340; i++) begin
        if ($urandom_range(99) < 70) q = unit_quat();
        else q = make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        pending_quats.push_back(q);
      end
      if (ph == 1) begin
        // Hold the sink off so the pipeline stalls and back-pressures input.
        hold_cycles = HOLD_LEN;
      end
      wait_drained();
      // Pause the sender until every result has come.
      pause_src = 1'b1;
      wait_drained();
      pause_src = 1'b0;
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0 && expected_angles.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
